// ===== src/assert_macros.svh =====
// Assertion helpers for the neighbour query table.
// Depends on a clock named clock and a synchronous reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define GNQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// When the condition holds, the property must hold at the following clock edge.
`define GNQ_ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) else $error(msg);

`endif

// ===== src/gnq_pkg.sv =====
// Shared types and constants for the neighbour query table.
// No dependencies.
package gnq_pkg;

   localparam int POS_W   = 24;
   localparam int REACH_W = 23;
   localparam int TAG_W   = 32;
   localparam int SLOT_W  = 6;
   localparam int OP_W    = 2;
   localparam int CSR_W   = 16;

   localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

   localparam logic [CSR_W-1:0] CELL_SIZE_RESET = 16'd32;

   typedef struct packed {
      logic [OP_W-1:0]          operation;
      logic [SLOT_W-1:0]        entity_slot;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic [REACH_W-1:0]       reach;
      logic [TAG_W-1:0]         tag;
   } req_type;

   typedef struct packed {
      logic [TAG_W-1:0] near_tag;
      logic             found;
      logic             last;
   } rsp_type;

endpackage

// ===== src/gnq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gnq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/grid_neighbor_query_table.sv =====
// Top level of the uniform-grid neighbour query table: sequencer, divider, multiplier.
// Depends on gnq_pkg, gnq_ram and assert_macros.svh.
//
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  gnq_pkg::req_type
// rsp      out        rsp_valid/rsp_ready  gnq_pkg::rsp_type
// csr      in         csr_wr_en            csr_wr_data (cell size)
//
// Remove is done in the idle state. Update reads the slot and, when the cell is
// recomputed, runs the bit-serial cell divider for x and then for y before the write.
// Query reads its own slot, squares its reach and scans all slots, skipping its own
// and free ones and comparing those in neighbouring cells by the shared 25x25
// multiplier, which squares dx and dy. A query of a free slot goes straight to the end.
// Reset clears the valid bits and returns the cell size to 32; slot data needs no clearing.
// A full result register stalls an emitting hit or the final beat until the beat is taken.
`include "assert_macros.svh"

module grid_neighbor_query_table #(
   parameter int MAX_ENTITIES  = 64,
   parameter int POS_FRAC_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  gnq_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output gnq_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [gnq_pkg::CSR_W-1:0]     csr_wr_data
);

   localparam int IDX_W  = $clog2(MAX_ENTITIES);
   localparam int DIV_W  = gnq_pkg::POS_W - POS_FRAC_BITS;
   localparam int CELL_W = DIV_W + 1;
   localparam int CNT_W  = $clog2(DIV_W + 1);
   localparam int DIFF_W = gnq_pkg::POS_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int RSQ_W  = 2 * gnq_pkg::REACH_W;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_U_RD   = 4'd1;
   localparam logic [3:0] ST_U_LD   = 4'd2;
   localparam logic [3:0] ST_D_LOAD = 4'd3;
   localparam logic [3:0] ST_D_STEP = 4'd4;
   localparam logic [3:0] ST_D_DONE = 4'd5;
   localparam logic [3:0] ST_U_WR   = 4'd6;
   localparam logic [3:0] ST_Q_RD   = 4'd7;
   localparam logic [3:0] ST_Q_LD   = 4'd8;
   localparam logic [3:0] ST_Q_RSQ  = 4'd9;
   localparam logic [3:0] ST_S_RD   = 4'd10;
   localparam logic [3:0] ST_S_LD   = 4'd11;
   localparam logic [3:0] ST_S_DX   = 4'd12;
   localparam logic [3:0] ST_S_DY   = 4'd13;
   localparam logic [3:0] ST_S_CMP  = 4'd14;
   localparam logic [3:0] ST_FIN    = 4'd15;

   typedef struct packed {
      logic signed [gnq_pkg::POS_W-1:0] pos_x;
      logic signed [gnq_pkg::POS_W-1:0] pos_y;
      logic [gnq_pkg::REACH_W-1:0]      reach;
      logic [gnq_pkg::TAG_W-1:0]        tag;
      logic signed [CELL_W-1:0]         cell_x;
      logic signed [CELL_W-1:0]         cell_y;
   } slot_word_type;

   // Registers and their next values.
   logic [3:0]                   state_ff, state_in;
   gnq_pkg::req_type             req_ff, req_in;
   logic [gnq_pkg::CSR_W-1:0]    cell_size_ff, cell_size_in;
   logic [MAX_ENTITIES-1:0]      valid_ff, valid_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   slot_word_type                word_ff, word_in;
   slot_word_type                qry_ff, qry_in;
   logic [gnq_pkg::TAG_W-1:0]    etag_ff, etag_in;
   logic [DIFF_W-1:0]            dx_ff, dx_in, dy_ff, dy_in;
   logic [RSQ_W-1:0]             rsq_ff, rsq_in;
   logic [PROD_W-1:0]            dsq_ff, dsq_in, prod_ff, prod_in;
   logic [gnq_pkg::CSR_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]             quo_ff, quo_in;
   logic                         neg_ff, neg_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         coord_ff, coord_in;
   logic                         pend_valid_ff, pend_valid_in;
   logic [gnq_pkg::TAG_W-1:0]    pend_tag_ff, pend_tag_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   gnq_pkg::rsp_type             rsp_ff, rsp_in;

   // Memory port signals.
   logic                         ram_we, ram_re;
   logic [IDX_W-1:0]             ram_waddr, ram_raddr;
   slot_word_type                ram_rdata;
   logic [$bits(slot_word_type)-1:0] ram_rbits;

   // Shared multiplier.
   logic [DIFF_W-1:0]            mul_a;
   logic [PROD_W-1:0]            mul_p;

   // Helper signals.
   logic                         req_fire, out_free, in_range;
   logic [IDX_W-1:0]             req_idx, slot_idx;
   logic [gnq_pkg::CSR_W-1:0]    divisor;
   logic [gnq_pkg::CSR_W:0]      div_sh;
   logic signed [gnq_pkg::POS_W-1:0] div_pos;
   logic [gnq_pkg::POS_W-1:0]    div_mag;
   logic signed [CELL_W-1:0]     cell_res;
   logic signed [CELL_W:0]       cdx, cdy;
   logic signed [DIFF_W-1:0]     pdx, pdy;
   logic                         adjacent, hit, skip_slot, last_idx;
   logic [PROD_W:0]              dist_sq;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign req_idx  = req_data.entity_slot[IDX_W-1:0];
   assign slot_idx = req_ff.entity_slot[IDX_W-1:0];
   assign in_range = ({1'b0, req_data.entity_slot} < (gnq_pkg::SLOT_W + 1)'(MAX_ENTITIES));
   assign divisor  = (cell_size_ff == '0) ? gnq_pkg::CSR_W'(1) : cell_size_ff;
   assign last_idx = (idx_ff == IDX_W'(MAX_ENTITIES - 1));

   // Slot store.
   assign ram_rdata = slot_word_type'(ram_rbits);
   assign ram_re    = (state_ff == ST_U_RD) || (state_ff == ST_Q_RD) || (state_ff == ST_S_RD);
   assign ram_raddr = (state_ff == ST_S_RD) ? idx_ff : slot_idx;
   assign ram_we    = (state_ff == ST_U_WR);
   assign ram_waddr = slot_idx;

   gnq_ram #(
      .WIDTH ($bits(slot_word_type)),
      .DEPTH (MAX_ENTITIES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (word_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rbits)
   );

   // The multiplier squares the reach, dx or dy depending on the step.
   always_comb begin
      case (state_ff)
         ST_S_DX: mul_a = dx_ff;
         ST_S_DY: mul_a = dy_ff;
         default: mul_a = DIFF_W'(qry_ff.reach);
      endcase
   end
   assign mul_p = mul_a * mul_a;

   // Divider: one restoring step per cycle on the whole-unit magnitude.
   assign div_pos  = coord_ff ? word_ff.pos_y : word_ff.pos_x;
   assign div_mag  = div_pos[gnq_pkg::POS_W-1] ? gnq_pkg::POS_W'(-div_pos)
                                               : gnq_pkg::POS_W'(div_pos);
   assign div_sh   = {rem_ff, quo_ff[DIV_W-1]};
   assign cell_res = neg_ff ? -CELL_W'(quo_ff) : CELL_W'(quo_ff);

   // Cell adjacency and coordinate differences for the slot under scan.
   assign cdx = {ram_rdata.cell_x[CELL_W-1], ram_rdata.cell_x}
              - {qry_ff.cell_x[CELL_W-1], qry_ff.cell_x};
   assign cdy = {ram_rdata.cell_y[CELL_W-1], ram_rdata.cell_y}
              - {qry_ff.cell_y[CELL_W-1], qry_ff.cell_y};
   assign adjacent = (cdx >= -(CELL_W + 1)'(1)) && (cdx <= (CELL_W + 1)'(1))
                  && (cdy >= -(CELL_W + 1)'(1)) && (cdy <= (CELL_W + 1)'(1));
   assign pdx = {ram_rdata.pos_x[gnq_pkg::POS_W-1], ram_rdata.pos_x}
              - {qry_ff.pos_x[gnq_pkg::POS_W-1], qry_ff.pos_x};
   assign pdy = {ram_rdata.pos_y[gnq_pkg::POS_W-1], ram_rdata.pos_y}
              - {qry_ff.pos_y[gnq_pkg::POS_W-1], qry_ff.pos_y};

   assign dist_sq   = {1'b0, dsq_ff} + {1'b0, prod_ff};
   assign hit       = (dist_sq <= (PROD_W + 1)'(rsq_ff));
   assign skip_slot = (gnq_pkg::SLOT_W'(idx_ff) == req_ff.entity_slot) || !valid_ff[idx_ff];

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      cell_size_in  = cell_size_ff;
      valid_in      = valid_ff;
      idx_in        = idx_ff;
      word_in       = word_ff;
      qry_in        = qry_ff;
      etag_in       = etag_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      rsq_in        = rsq_ff;
      dsq_in        = dsq_ff;
      prod_in       = prod_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      neg_in        = neg_ff;
      cnt_in        = cnt_ff;
      coord_in      = coord_ff;
      pend_valid_in = pend_valid_ff;
      pend_tag_in   = pend_tag_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;

      if (csr_wr_en) begin
         cell_size_in = csr_wr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               req_in = req_data;
               case (req_data.operation)
                  gnq_pkg::OP_UPDATE: begin
                     if (in_range) begin
                        state_in = ST_U_RD;
                     end
                  end
                  gnq_pkg::OP_REMOVE: begin
                     if (in_range) begin
                        valid_in[req_idx] = 1'b0;
                     end
                  end
                  gnq_pkg::OP_QUERY: begin
                     if (in_range && valid_ff[req_idx]) begin
                        state_in = ST_Q_RD;
                     end else begin
                        state_in = ST_FIN;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_U_RD: begin
            state_in = ST_U_LD;
         end
         ST_U_LD: begin
            // A moved or new entity needs its cell worked out again.
            if (valid_ff[slot_idx] && ram_rdata.pos_x == req_ff.pos_x
                  && ram_rdata.pos_y == req_ff.pos_y) begin
               word_in       = ram_rdata;
               word_in.reach = req_ff.reach;
               state_in      = ST_U_WR;
            end else begin
               word_in.pos_x = req_ff.pos_x;
               word_in.pos_y = req_ff.pos_y;
               word_in.reach = req_ff.reach;
               word_in.tag   = valid_ff[slot_idx] ? ram_rdata.tag : req_ff.tag;
               coord_in      = 1'b0;
               state_in      = ST_D_LOAD;
            end
         end
         ST_D_LOAD: begin
            rem_in   = '0;
            quo_in   = DIV_W'(div_mag >> POS_FRAC_BITS);
            neg_in   = div_pos[gnq_pkg::POS_W-1];
            cnt_in   = '0;
            state_in = ST_D_STEP;
         end
         ST_D_STEP: begin
            if (div_sh >= {1'b0, divisor}) begin
               rem_in = gnq_pkg::CSR_W'(div_sh - {1'b0, divisor});
               quo_in = {quo_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_in = div_sh[gnq_pkg::CSR_W-1:0];
               quo_in = {quo_ff[DIV_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_W - 1)) begin
               state_in = ST_D_DONE;
            end
         end
         ST_D_DONE: begin
            if (coord_ff) begin
               word_in.cell_y = cell_res;
               state_in       = ST_U_WR;
            end else begin
               word_in.cell_x = cell_res;
               coord_in       = 1'b1;
               state_in       = ST_D_LOAD;
            end
         end
         ST_U_WR: begin
            valid_in[slot_idx] = 1'b1;
            state_in           = ST_IDLE;
         end
         ST_Q_RD: begin
            state_in = ST_Q_LD;
         end
         ST_Q_LD: begin
            qry_in   = ram_rdata;
            state_in = ST_Q_RSQ;
         end
         ST_Q_RSQ: begin
            rsq_in   = RSQ_W'(mul_p);
            idx_in   = '0;
            state_in = ST_S_RD;
         end
         ST_S_RD: begin
            if (!skip_slot) begin
               state_in = ST_S_LD;
            end else if (last_idx) begin
               state_in = ST_FIN;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_S_LD: begin
            etag_in = ram_rdata.tag;
            dx_in   = pdx[DIFF_W-1] ? DIFF_W'(-pdx) : DIFF_W'(pdx);
            dy_in   = pdy[DIFF_W-1] ? DIFF_W'(-pdy) : DIFF_W'(pdy);
            if (adjacent) begin
               state_in = ST_S_DX;
            end else if (last_idx) begin
               state_in = ST_FIN;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_S_RD;
            end
         end
         ST_S_DX: begin
            dsq_in   = mul_p;
            state_in = ST_S_DY;
         end
         ST_S_DY: begin
            prod_in  = mul_p;
            state_in = ST_S_CMP;
         end
         ST_S_CMP: begin
            // A new hit pushes out the one held back, which is then known not to be last.
            if (!(hit && pend_valid_ff && !out_free)) begin
               if (hit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{near_tag: pend_tag_ff, found: 1'b1, last: 1'b0};
                  end
                  pend_valid_in = 1'b1;
                  pend_tag_in   = etag_ff;
               end
               if (last_idx) begin
                  state_in = ST_FIN;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_S_RD;
               end
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_in        = pend_valid_ff
                             ? gnq_pkg::rsp_type'{near_tag: pend_tag_ff, found: 1'b1,
                                                  last: 1'b1}
                             : gnq_pkg::rsp_type'{near_tag: '0, found: 1'b0, last: 1'b1};
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cell_size_ff  <= gnq_pkg::CELL_SIZE_RESET;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cell_size_ff  <= cell_size_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      word_ff     <= word_in;
      qry_ff      <= qry_in;
      etag_ff     <= etag_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      rsq_ff      <= rsq_in;
      dsq_ff      <= dsq_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      neg_ff      <= neg_in;
      cnt_ff      <= cnt_in;
      coord_ff    <= coord_in;
      pend_tag_ff <= pend_tag_in;
      rsp_ff      <= rsp_in;
   end

   // Checks on the sequencer.
   `GNQ_ASSERT(a_notfound_is_last, !rsp_valid_ff || rsp_ff.found || rsp_ff.last, "not-found beat without last")
   `GNQ_ASSERT(a_idle_no_pending, (state_ff != ST_IDLE) || !pend_valid_ff, "held result left over at idle")
   `GNQ_ASSERT(a_div_count, (state_ff != ST_D_STEP) || (cnt_ff < CNT_W'(DIV_W)), "divider ran too long")
   `GNQ_ASSERT_NEXT(a_write_sets_valid, state_ff == ST_U_WR, valid_ff[$past(slot_idx)], "slot not valid after write")

endmodule
